// ===== rtl/core/sync_length_frame_deframer_assert.svh =====
// Assertion macros used by the deframer core.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, held off during rst.
`define SLFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk, held off during rst.
`define SLFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLFD_ASSERT_IMP(lbl, ante, cons, msg)
`define SLFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/slfd_pkg.sv =====
// Shared constants and types of the sync/length frame deframer.
package slfd_pkg;

  localparam int FRAME_CAPACITY = 2048;
  localparam int HDR_BYTES      = 10;
  localparam int LEAD_BYTES     = 4;
  localparam int HIST_BYTES     = HDR_BYTES - 1;
  localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);
  localparam int FILL_W         = $clog2(HDR_BYTES);
  localparam int FIELD_W        = 16;
  localparam int SUM_W          = FIELD_W + 1;

  localparam logic [7:0] LEAD_PATTERN [LEAD_BYTES] = '{8'h01, 8'hA5, 8'h01, 8'h5A};

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] seq;
    logic [FIELD_W-1:0] ftype;
    logic [FIELD_W-1:0] len;
    logic [7:0]         pbyte;
    logic               last;
  } result_t;

endpackage

// ===== rtl/core/slfd_core.sv =====
// Frame search window, header latch and payload tracking.
`include "sync_length_frame_deframer_assert.svh"
module slfd_core import slfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  logic [7:0]         win [HIST_BYTES];
  logic [FILL_W-1:0]  fill, fill_next;
  logic               phase, phase_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [FIELD_W-1:0] hseq, hseq_next;
  logic [FIELD_W-1:0] htype, htype_next;
  logic [FIELD_W-1:0] hlen, hlen_next;
  logic               shift_win;
  logic               lead_ok;
  logic [CNT_W-1:0]   cnt_inc;
  logic               frame_end;
  logic [FIELD_W-1:0] new_len;

  // leading pattern sits in the oldest four held bytes once the window fills
  always_comb begin
    lead_ok = 1'b1;
    for (int i = 0; i < LEAD_BYTES; i++) begin
      lead_ok = lead_ok & (win[i] == LEAD_PATTERN[i]);
    end
  end

  assign cnt_inc   = cnt + CNT_W'(1);
  assign frame_end = SUM_W'(cnt_inc) >= (SUM_W'(HDR_BYTES) + SUM_W'(hlen));
  assign new_len   = {rx_byte, win[HIST_BYTES-1]};

  // next state and result for the byte on rx_byte
  always_comb begin
    phase_next = phase;
    fill_next  = fill;
    cnt_next   = cnt;
    hseq_next  = hseq;
    htype_next = htype;
    hlen_next  = hlen;
    shift_win  = 1'b0;
    res_valid  = 1'b0;
    res.kind   = KIND_PAYLOAD;
    res.pbyte  = 8'd0;
    res.last   = 1'b0;
    if (phase) begin
      if (cnt >= CNT_W'(FRAME_CAPACITY)) begin
        // overflow: drop frame, byte restarts the search
        res_valid  = 1'b1;
        res.kind   = KIND_DROP;
        res.last   = 1'b1;
        phase_next = 1'b0;
        cnt_next   = '0;
        shift_win  = 1'b1;
        fill_next  = FILL_W'(1);
      end else begin
        res_valid = 1'b1;
        res.pbyte = rx_byte;
        cnt_next  = cnt_inc;
        if (frame_end) begin
          res.last   = 1'b1;
          phase_next = 1'b0;
          cnt_next   = '0;
        end
      end
    end else begin
      shift_win = 1'b1;
      if (fill != FILL_W'(HIST_BYTES)) begin
        fill_next = fill + FILL_W'(1);
      end else if (lead_ok) begin
        hseq_next  = {win[5], win[4]};
        htype_next = {win[7], win[6]};
        hlen_next  = new_len;
        fill_next  = '0;
        if (new_len == '0) begin
          res_valid = 1'b1;
          res.kind  = KIND_EMPTY;
          res.last  = 1'b1;
        end else begin
          phase_next = 1'b1;
          cnt_next   = CNT_W'(HDR_BYTES);
        end
      end
    end
    res.seq   = hseq_next;
    res.ftype = htype_next;
    res.len   = hlen_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      fill  <= '0;
      cnt   <= '0;
    end else if (take) begin
      phase <= phase_next;
      fill  <= fill_next;
      cnt   <= cnt_next;
    end
  end

  // header fields and search window
  always_ff @(posedge clk) begin
    if (take) begin
      hseq  <= hseq_next;
      htype <= htype_next;
      hlen  <= hlen_next;
      if (shift_win) begin
        for (int i = 0; i < HIST_BYTES - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[HIST_BYTES-1] <= rx_byte;
      end
    end
  end

  `SLFD_ASSERT_IMP(a_payload_fill_clear, phase, fill == '0, "window fill set in payload phase")
  `SLFD_ASSERT_IMP(a_search_cnt_clear, !phase, cnt == '0, "byte count set while searching")
  `SLFD_ASSERT_IMP(a_cnt_range, phase,
    (cnt >= CNT_W'(HDR_BYTES)) && (cnt <= CNT_W'(FRAME_CAPACITY)), "byte count out of range")
  `SLFD_ASSERT_IMP(a_special_last, res_valid && (res.kind != KIND_PAYLOAD), res.last,
    "empty or drop result without last")
  `SLFD_ASSERT_NXT(a_end_to_search, take && res_valid && res.last, !phase,
    "still in payload after final result")

endmodule

// ===== rtl/core/slfd_skid.sv =====
// Two-entry output register with skid slot.
module slfd_skid import slfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid  <= skid_valid | push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/core/sync_length_frame_deframer.sv =====
// Top level of the sync/length frame deframer.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------------------------
//   input   | in_valid  | in_stall  | rx_byte
//   output  | out_valid | out_stall | result_kind frame_seq frame_type
//           |           |           | frame_length payload_byte last
//
// One byte per cycle while in_stall is low: each request is handled in the cycle
// it is taken, and any result it yields is registered in the output register,
// or in the skid slot when the output is stalled.
// A two-entry output register decouples the sides; in_stall rises only when
// a result waits in the skid slot behind a stalled output.
// rst (synchronous) returns the block to sync search with an empty window.
module sync_length_frame_deframer import slfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [FIELD_W-1:0] frame_seq,
  output logic [FIELD_W-1:0] frame_type,
  output logic [FIELD_W-1:0] frame_length,
  output logic [7:0]         payload_byte,
  output logic               last
);

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign take = in_valid && !in_stall;

  slfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  slfd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign result_kind  = out_data.kind;
  assign frame_seq    = out_data.seq;
  assign frame_type   = out_data.ftype;
  assign frame_length = out_data.len;
  assign payload_byte = out_data.pbyte;
  assign last         = out_data.last;

endmodule
